>>> hdl/lcc_pkg.sv
// Shared constants and types for the line collision checker.
// Used by lcc_walker and line_collision_check; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lcc_pkg;

  // Default side length of the square occupancy map, in cells.
  localparam int MAP_DIM_DEF = 1024;

  // Width of every coordinate field on the input channel.
  localparam int COORD_W = 10;

  // Signed width of the line error term and the deltas.
  localparam int ERR_W = 13;

  // Request kinds carried by req_type.
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_CHECK = 1'b1;

  // Control from the sequencer to the line walker.
  typedef struct packed {
    logic load;
    logic step;
  } walk_ctrl_t;

endpackage

`default_nettype wire

>>> hdl/lcc_map_mem.sv
// Occupancy bitmap: one bit per cell, one write port and one registered read port.
// Standalone; the address is formed by the top level as {row, column}.
`timescale 1ns / 1ps
`default_nettype none

module lcc_map_mem #(
  parameter int AW = 20
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic          wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic               rdata
);

  localparam int DEPTH = 1 << AW;

  logic mem [0:DEPTH-1];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> hdl/lcc_walker.sv
// Bresenham line stepper: clamps the endpoints, then advances one cell per step.
// Depends on lcc_pkg for coordinate widths and the walk control struct.
`timescale 1ns / 1ps
`default_nettype none

module lcc_walker #(
  parameter int MAP_DIM = lcc_pkg::MAP_DIM_DEF
) (
  input  wire logic                          clk,
  input  wire lcc_pkg::walk_ctrl_t           ctrl,
  input  wire logic [lcc_pkg::COORD_W-1:0]   start_x,
  input  wire logic [lcc_pkg::COORD_W-1:0]   start_y,
  input  wire logic [lcc_pkg::COORD_W-1:0]   end_x,
  input  wire logic [lcc_pkg::COORD_W-1:0]   end_y,
  output logic      [lcc_pkg::COORD_W-1:0]   cur_x,
  output logic      [lcc_pkg::COORD_W-1:0]   cur_y,
  output logic                               at_target
);

  import lcc_pkg::*;

  logic [COORD_W-1:0]     target_x;
  logic [COORD_W-1:0]     target_y;
  logic signed [ERR_W-1:0] line_error;
  logic signed [ERR_W-1:0] dx;
  logic signed [ERR_W-1:0] dy;
  logic                    step_x_up;
  logic                    step_y_up;

  logic [COORD_W-1:0]      x0;
  logic [COORD_W-1:0]      y0;
  logic [COORD_W-1:0]      x1;
  logic [COORD_W-1:0]      y1;
  logic signed [ERR_W-1:0] dx_new;
  logic signed [ERR_W-1:0] dy_new;
  logic signed [ERR_W:0]   e2;
  logic                    move_x;
  logic                    move_y;
  logic signed [ERR_W-1:0] err_next;

  // Coordinates past the map edge are pulled back to the last row or column.
  function automatic logic [COORD_W-1:0] clamp(input logic [COORD_W-1:0] v);
    logic [COORD_W-1:0] r;
    r = v;
    if (32'(v) > MAP_DIM - 1) begin
      r = COORD_W'(MAP_DIM - 1);
    end
    return r;
  endfunction

  // Clamped endpoints and initial deltas for a new segment.
  always_comb begin
    x0 = clamp(start_x);
    y0 = clamp(start_y);
    x1 = clamp(end_x);
    y1 = clamp(end_y);
    dx_new = (x1 > x0) ? ERR_W'(x1 - x0) : ERR_W'(x0 - x1);
    dy_new = (y1 > y0) ? -ERR_W'(y1 - y0) : -ERR_W'(y0 - y1);
  end

  // One Bresenham decision from the current error term.
  always_comb begin
    e2       = {line_error, 1'b0};
    move_x   = (e2 >= (ERR_W+1)'(dy));
    move_y   = (e2 <= (ERR_W+1)'(dx));
    err_next = line_error + (move_x ? dy : '0) + (move_y ? dx : '0);
  end

  assign at_target = (cur_x == target_x) && (cur_y == target_y);

  // Walk registers: loaded at the start of a check, advanced once per step.
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      cur_x      <= x0;
      cur_y      <= y0;
      target_x   <= x1;
      target_y   <= y1;
      dx         <= dx_new;
      dy         <= dy_new;
      step_x_up  <= (x0 < x1);
      step_y_up  <= (y0 < y1);
      line_error <= dx_new + dy_new;
    end else if (ctrl.step) begin
      line_error <= err_next;
      if (move_x) begin
        cur_x <= step_x_up ? cur_x + 1'b1 : cur_x - 1'b1;
      end
      if (move_y) begin
        cur_y <= step_y_up ? cur_y + 1'b1 : cur_y - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

>>> hdl/line_collision_check.sv
// Line collision checker over a square occupancy bitmap.
// The input channel carries two kinds of transaction. A write (req_type = 0) sets
// one map cell to blocked or free and gives no result, and a write outside the map
// is dropped. A check (req_type = 1) walks the Bresenham line between two
// clamped endpoints and gives one result transaction on the output channel:
// collision = 1 at the first blocked cell, 0 if all are free.
// A check issues one map read per cycle, pipelined behind the registered read of
// the bitmap memory, and reads at most the longer of the two deltas plus one
// cells, so at most MAP_DIM; the result passes through the finish state into the
// output register.
// Items are handled one at a time.
// The result sits in an output register, so the next item can be accepted while
// the receiver stalls; a second result waits in the sequencer until the output
// register is drained.
// After reset the bitmap is cleared by a sweep of one cell per cycle over
// 2^(2*ceil(log2(MAP_DIM))) cells (1048576 cells for a 1024 map); no input is
// accepted during the sweep.
// Depends on lcc_pkg, lcc_walker and lcc_map_mem.
`timescale 1ns / 1ps
`default_nettype none

module line_collision_check #(
  parameter int MAP_DIM = lcc_pkg::MAP_DIM_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic                        req_type,
  input  wire logic [lcc_pkg::COORD_W-1:0] cell_x,
  input  wire logic [lcc_pkg::COORD_W-1:0] cell_y,
  input  wire logic                        cell_blocked,
  input  wire logic [lcc_pkg::COORD_W-1:0] start_x,
  input  wire logic [lcc_pkg::COORD_W-1:0] start_y,
  input  wire logic [lcc_pkg::COORD_W-1:0] end_x,
  input  wire logic [lcc_pkg::COORD_W-1:0] end_y,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic                             collision
);

  import lcc_pkg::*;

  localparam int CW = $clog2(MAP_DIM);
  localparam int AW = 2 * CW;

  localparam logic [1:0] ST_CLEAR  = 2'd0;
  localparam logic [1:0] ST_IDLE   = 2'd1;
  localparam logic [1:0] ST_WALK   = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  logic [1:0]         state;
  logic [1:0]         state_next;
  logic [AW-1:0]      clr_addr;
  logic               issuing;
  logic               rd_valid;
  logic               rd_last;
  logic               hit;

  logic               accept;
  logic               write_ok;
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic               mem_wdata;
  logic               mem_q;
  logic [AW-1:0]      mem_raddr;
  logic               finish;
  logic               out_free;
  walk_ctrl_t         walk_ctrl;
  logic [COORD_W-1:0] cur_x;
  logic [COORD_W-1:0] cur_y;
  logic               at_target;

  // Fit a coordinate field to the map's address slice.
  function automatic logic [CW-1:0] to_cw(input logic [COORD_W-1:0] v);
    logic [15:0] w;
    w = 16'(v);
    return w[CW-1:0];
  endfunction

  // Handshake and request decode.
  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign write_ok = (32'(cell_x) < MAP_DIM) && (32'(cell_y) < MAP_DIM);
  assign out_free = !out_valid || out_ready;

  // Memory write side: clearing sweep after reset, else map writes.
  always_comb begin
    if (state == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr;
      mem_wdata = 1'b0;
    end else begin
      mem_we    = accept && (req_type == REQ_WRITE) && write_ok;
      mem_waddr = {to_cw(cell_y), to_cw(cell_x)};
      mem_wdata = cell_blocked;
    end
  end

  // Walk control and the stop decision on returned read data.
  assign mem_raddr      = {to_cw(cur_y), to_cw(cur_x)};
  assign walk_ctrl.load = accept && (req_type == REQ_CHECK);
  assign walk_ctrl.step = issuing && !at_target;
  assign finish         = (state == ST_WALK) && rd_valid && (mem_q || rd_last);

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_addr == '1) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (walk_ctrl.load) state_next = ST_WALK;
      end
      ST_WALK: begin
        if (finish) state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Sequencer registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      issuing  <= 1'b0;
      rd_valid <= 1'b0;
      rd_last  <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (walk_ctrl.load) begin
        issuing  <= 1'b1;
        rd_valid <= 1'b0;
      end else if (finish) begin
        issuing  <= 1'b0;
        rd_valid <= 1'b0;
      end else begin
        rd_valid <= issuing;
        rd_last  <= at_target;
        if (issuing && at_target) begin
          issuing <= 1'b0;
        end
      end
    end
  end

  // Result held between the end of a walk and the output register.
  always_ff @(posedge clk) begin
    if (finish) begin
      hit <= mem_q;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_FINISH && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FINISH && out_free) begin
      collision <= hit;
    end
  end

  lcc_walker #(
    .MAP_DIM (MAP_DIM)
  ) u_walker (
    .clk       (clk),
    .ctrl      (walk_ctrl),
    .start_x   (start_x),
    .start_y   (start_y),
    .end_x     (end_x),
    .end_y     (end_y),
    .cur_x     (cur_x),
    .cur_y     (cur_y),
    .at_target (at_target)
  );

  lcc_map_mem #(
    .AW (AW)
  ) u_map (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (issuing),
    .raddr (mem_raddr),
    .rdata (mem_q)
  );

`ifndef ASSERT_OFF
  // Reads are only in flight while a walk is running.
  assert property (@(posedge clk) disable iff (rst)
    rd_valid |-> (state == ST_WALK))
    else $error("map read pending outside a walk");

  // The map is never written while a walk reads it.
  assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state != ST_WALK))
    else $error("map write during a walk");

  // A new result only appears after a walk has finished.
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == ST_FINISH))
    else $error("result without a finished walk");

  // Once the data of the last read returns, the walk moves to the finish state in the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_WALK && rd_valid && rd_last) |=> (state == ST_FINISH))
    else $error("walk did not stop at its end cell");
`endif

endmodule

`default_nettype wire
